// ===== rtl/rigid_body_velocity_integrator_2d_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 2D velocity integrator
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_VELOCITY_INTEGRATOR_2D_MACROS_SVH
`define RIGID_BODY_VELOCITY_INTEGRATOR_2D_MACROS_SVH

// Same-cycle implication
`define RBVI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RBVI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbvi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbvi_pkg
// Shared types, register codes and reset constants of the 2D velocity
// integrator.
// ----------------------------------------------------------------------------
package rbvi_pkg;

    localparam int VALUE_BITS_DEF = 40;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_BITS       = 39;
    localparam int CFG_IDX_BITS   = 3;

    // Reset values in whole units, stored shifted by the fraction width
    localparam int unsigned MASS_K = 1;
    localparam int unsigned FRIC_K = 754;
    localparam int unsigned VLIM_K = 800;
    localparam int unsigned GLIM_K = 700;
    localparam int unsigned GACC_K = 50000;
    // Horizontal air drag per second
    localparam int unsigned DRAG_K = 300;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ENABLED        = 3'd0,
        REG_GRAVITY_USE    = 3'd1,
        REG_AIR_FRICTION   = 3'd2,
        REG_MASS           = 3'd3,
        REG_FRICTION_RATE  = 3'd4,
        REG_VELOCITY_LIMIT = 3'd5,
        REG_GRAVITY_LIMIT  = 3'd6,
        REG_GRAVITY_ACCEL  = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIVX,
        S_MULX,
        S_DIVY,
        S_MULY,
        S_FR1,
        S_FR2,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_SCX,
        S_SDX,
        S_SCY,
        S_SDY,
        S_GRAV,
        S_CLAMP,
        S_POSX,
        S_POSY,
        S_OUT
    } t_state;

    // What a vector length is wanted for
    typedef enum logic [1:0] {
        PH_FRIC,
        PH_AIR,
        PH_LIM
    } t_phase;

    // k shifted into fixed point, saturated to the register width
    function automatic logic [CFG_BITS-1:0] f_cfg_reset(input int unsigned k,
                                                        input int unsigned frac);
        logic [63:0] v;
        logic [63:0] mx;
        v  = 64'(k) << frac;
        mx = (64'(1) << CFG_BITS) - 64'(1);
        return (v > mx) ? mx[CFG_BITS-1:0] : v[CFG_BITS-1:0];
    endfunction

endpackage

// ===== rtl/rbvi_alu.sv =====
// ----------------------------------------------------------------------------
// rbvi_alu
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module rbvi_alu #(
    parameter int W  = rbvi_pkg::VALUE_BITS_DEF,
    parameter int NW = 2 * rbvi_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbvi_pkg::t_alu_ctl i_ctl,
    input  logic [NW-1:0]      i_a,
    input  logic [W-1:0]       i_b,
    output logic               o_done,
    output logic [NW-1:0]      o_res
);

    localparam int CNTW = $clog2(NW + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    rbvi_pkg::t_alu_op   r_op, n_op;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [NW-1:0]       r_a, n_a;
    logic [W-1:0]        r_b, n_b;
    logic [NW-1:0]       r_acc, n_acc;
    logic [W:0]          r_rem, n_rem;
    logic [W-1:0]        r_root, n_root;

    logic [W:0]          w_msum;
    logic [W:0]          w_dsh;
    logic                w_dge;
    logic [W+2:0]        w_rsh;
    logic [W+2:0]        w_rtr;
    logic                w_rge;
    logic [W+2:0]        w_rdif;

    // Serial datapath steps
    assign w_msum = (W+1)'(r_acc[NW-1:W]) + (r_b[0] ? (W+1)'(r_a[W-1:0]) : '0);
    assign w_dsh  = {r_rem[W-1:0], r_a[NW-1]};
    assign w_dge  = (w_dsh >= {1'b0, r_b});
    assign w_rsh  = {r_rem, r_a[NW-1:NW-2]};
    assign w_rtr  = {1'b0, r_root, 2'b01};
    assign w_rge  = (w_rsh >= w_rtr);
    assign w_rdif = w_rsh - w_rtr;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_ctl.start) begin
            // Load operands and the step count
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = (i_ctl.op == rbvi_pkg::OP_DIV) ? CNTW'(NW) : CNTW'(W);
        end else if (r_busy) begin
            case (r_op)
                rbvi_pkg::OP_MUL: begin
                    n_acc = {w_msum, r_acc[W-1:1]};
                    n_b   = r_b >> 1;
                end
                rbvi_pkg::OP_DIV: begin
                    n_rem = w_dge ? (w_dsh - {1'b0, r_b}) : w_dsh;
                    n_acc = {r_acc[NW-2:0], w_dge};
                    n_a   = r_a << 1;
                end
                rbvi_pkg::OP_SQRT: begin
                    n_rem  = w_rge ? w_rdif[W:0] : w_rsh[W:0];
                    n_root = {r_root[W-2:0], w_rge};
                    n_a    = r_a << 2;
                end
                default: begin
                    n_acc = '0;
                end
            endcase
            n_cnt = r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= rbvi_pkg::OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_res  = (r_op == rbvi_pkg::OP_SQRT) ? NW'(r_root) : r_acc;

endmodule

// ===== rtl/rigid_body_velocity_integrator_2d.sv =====
// ----------------------------------------------------------------------------
// rigid_body_velocity_integrator_2d
// Semi-implicit Euler step of a 2D body velocity and position in signed fixed
// point, with friction, air drag, gravity and speed limits.
// ----------------------------------------------------------------------------
// One tick at a time: a sequencer steps the work through a single bit-serial
// unit (multiply, divide and square root). The work of an enabled tick
// depends on how many divides and vector lengths the friction and limit
// paths need; a disabled tick goes from idle straight to the output state
// without using the unit. A new tick is taken while the previous result
// still waits in the output register.
// Configuration writes are always accepted and should only be made while idle.
// ----------------------------------------------------------------------------
`include "rigid_body_velocity_integrator_2d_macros.svh"

module rigid_body_velocity_integrator_2d #(
    parameter int VALUE_BITS = rbvi_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = rbvi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rbvi_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [rbvi_pkg::CFG_BITS-1:0]          i_cfg_data,
    // Tick input
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // force_x, force_y, delta_time, pos_x, pos_y (low to high), zero padded
    input  logic [((4*VALUE_BITS+FRAC_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    // on_ground
    input  logic                                   i_s_axis_tuser,
    // Result output
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // new_pos_x, new_pos_y, vel_x, vel_y (low to high), zero padded
    output logic [((4*VALUE_BITS+7)/8)*8-1:0]      o_m_axis_tdata
);

    localparam int W       = VALUE_BITS;
    localparam int F       = FRAC_BITS;
    localparam int NW      = 2 * W;
    localparam int DTW     = F + 1;
    localparam int CB      = rbvi_pkg::CFG_BITS;
    localparam int CW      = (CB > W) ? CB : W;
    localparam int XW      = (DTW + 9 > W) ? DTW + 9 : W;
    localparam int OUT_TDW = ((4*W+7)/8)*8;
    localparam int DT_LO   = 2*W;
    localparam int PX_LO   = 2*W + DTW;
    localparam int PY_LO   = 3*W + DTW;

    localparam logic [W-1:0] MAXP_U = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    localparam logic [CB-1:0] RST_MASS = rbvi_pkg::f_cfg_reset(rbvi_pkg::MASS_K, F);
    localparam logic [CB-1:0] RST_FRIC = rbvi_pkg::f_cfg_reset(rbvi_pkg::FRIC_K, F);
    localparam logic [CB-1:0] RST_VLIM = rbvi_pkg::f_cfg_reset(rbvi_pkg::VLIM_K, F);
    localparam logic [CB-1:0] RST_GLIM = rbvi_pkg::f_cfg_reset(rbvi_pkg::GLIM_K, F);
    localparam logic [CB-1:0] RST_GACC = rbvi_pkg::f_cfg_reset(rbvi_pkg::GACC_K, F);

    // ---- fixed-point helpers ----
    function automatic logic [W-1:0] f_mag(input logic signed [W-1:0] v);
        logic [W-1:0] u;
        u = v;
        return u[W-1] ? (~u + W'(1)) : u;
    endfunction

    // Saturate a magnitude to the signed range and apply the sign
    function automatic logic signed [W-1:0] f_make(input logic neg,
                                                   input logic [NW-1:0] mag);
        logic [NW-1:0] lim;
        logic [W-1:0]  l;
        lim = neg ? (NW'(MAXP_U) + NW'(1)) : NW'(MAXP_U);
        l   = (mag > lim) ? lim[W-1:0] : mag[W-1:0];
        return neg ? $signed(~l + W'(1)) : $signed(l);
    endfunction

    function automatic logic signed [W-1:0] f_sadd(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? MINN : MAXP;
        end
        return $signed(s[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] f_ssub(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? MINN : MAXP;
        end
        return $signed(s[W-1:0]);
    endfunction

    // Register value read as a non-negative signed quantity
    function automatic logic [W-1:0] f_cfg(input logic [CB-1:0] r);
        logic [CW-1:0] x;
        x = CW'(r);
        return (x > CW'(MAXP_U)) ? MAXP_U : x[W-1:0];
    endfunction

    // ---- registers ----
    logic                  r_enabled, r_grav, r_air;
    logic [CB-1:0]         r_mass, r_fric, r_vlim, r_glim, r_gacc;

    rbvi_pkg::t_state      r_state, n_state;
    rbvi_pkg::t_phase      r_phase, n_phase;
    logic                  r_issued, n_issued;
    logic                  r_out_valid, n_out_valid;
    logic signed [W-1:0]   r_vx, n_vx, r_vy, n_vy;
    logic signed [W-1:0]   r_fx, n_fx, r_fy, n_fy;
    logic signed [W-1:0]   r_px, n_px, r_py, n_py;
    logic [DTW-1:0]        r_dt, n_dt;
    logic                  r_ground, n_ground;
    logic signed [W-1:0]   r_t, n_t;
    logic [W-1:0]          r_s, n_s;
    logic [W-1:0]          r_len, n_len;
    logic [NW-1:0]         r_wide, n_wide;
    logic [4*W-1:0]        r_out_data, n_out_data;

    // ---- datapath wires ----
    rbvi_pkg::t_alu_ctl    w_ctl;
    logic [NW-1:0]         w_a;
    logic [W-1:0]          w_b;
    logic                  w_alu_done;
    logic [NW-1:0]         w_res;
    logic [NW-1:0]         w_prod_f;
    logic                  w_in_acc;
    logic                  w_work;
    logic [W-1:0]          w_mvx, w_mvy, w_mt, w_m, w_vl, w_gl, w_drag, w_dt;
    logic [XW-1:0]         w_drag_x;
    logic signed [W-1:0]   w_sres;
    logic                  w_fric, w_air, w_gr;
    logic                  l_lim;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == rbvi_pkg::S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDW'(r_out_data);

    assign w_mvx    = f_mag(r_vx);
    assign w_mvy    = f_mag(r_vy);
    assign w_mt     = f_mag(r_t);
    assign w_m      = f_cfg(r_mass);
    assign w_vl     = f_cfg(r_vlim);
    assign w_gl     = f_cfg(r_glim);
    assign w_dt     = W'(r_dt);
    assign w_drag_x = XW'(r_dt) * XW'(rbvi_pkg::DRAG_K);
    assign w_drag   = (w_drag_x > XW'(MAXP_U)) ? MAXP_U : w_drag_x[W-1:0];
    assign w_prod_f = w_res >> F;
    assign w_sres   = f_make(1'b0, w_prod_f);
    assign w_fric   = !r_grav || r_ground;
    assign w_air    = r_grav && !r_ground && r_air;
    assign w_gr     = r_grav && !r_ground;

    assign w_work = (r_state != rbvi_pkg::S_IDLE) && (r_state != rbvi_pkg::S_CLAMP)
                 && (r_state != rbvi_pkg::S_OUT);

    // Select operands and operation of the serial unit
    always_comb begin
        w_ctl.start = w_work && !r_issued;
        w_ctl.op    = rbvi_pkg::OP_MUL;
        w_a         = '0;
        w_b         = '0;
        case (r_state)
            rbvi_pkg::S_DIVX: begin
                w_ctl.op = rbvi_pkg::OP_DIV;
                w_a      = NW'(f_mag(r_fx)) << F;
                w_b      = w_m;
            end
            rbvi_pkg::S_DIVY: begin
                w_ctl.op = rbvi_pkg::OP_DIV;
                w_a      = NW'(f_mag(r_fy)) << F;
                w_b      = w_m;
            end
            rbvi_pkg::S_MULX, rbvi_pkg::S_MULY, rbvi_pkg::S_FR2: begin
                w_a = NW'(w_mt);
                w_b = w_dt;
            end
            rbvi_pkg::S_FR1: begin
                w_a = NW'(f_cfg(r_fric));
                w_b = w_m;
            end
            rbvi_pkg::S_SQX: begin
                w_a = NW'(w_mvx);
                w_b = w_mvx;
            end
            rbvi_pkg::S_SQY: begin
                w_a = NW'(w_mvy);
                w_b = w_mvy;
            end
            rbvi_pkg::S_SQRT: begin
                w_ctl.op = rbvi_pkg::OP_SQRT;
                w_a      = r_wide;
            end
            rbvi_pkg::S_SCX: begin
                w_a = NW'(w_mvx);
                w_b = r_s;
            end
            rbvi_pkg::S_SCY: begin
                w_a = NW'(w_mvy);
                w_b = r_s;
            end
            rbvi_pkg::S_SDX, rbvi_pkg::S_SDY: begin
                w_ctl.op = rbvi_pkg::OP_DIV;
                w_a      = r_wide;
                w_b      = r_len;
            end
            rbvi_pkg::S_GRAV: begin
                w_a = NW'(f_cfg(r_gacc));
                w_b = w_dt;
            end
            rbvi_pkg::S_POSX: begin
                w_a = NW'(w_mvx);
                w_b = w_dt;
            end
            rbvi_pkg::S_POSY: begin
                w_a = NW'(w_mvy);
                w_b = w_dt;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    rbvi_alu #(
        .W  (W),
        .NW (NW)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_alu_done),
        .o_res   (w_res)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_issued    = r_issued;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_px        = r_px;
        n_py        = r_py;
        n_dt        = r_dt;
        n_ground    = r_ground;
        n_t         = r_t;
        n_s         = r_s;
        n_len       = r_len;
        n_wide      = r_wide;
        n_out_data  = r_out_data;
        l_lim       = 1'b0;

        if (w_ctl.start) begin
            n_issued = 1'b1;
        end
        if (w_alu_done) begin
            n_issued = 1'b0;
        end

        case (r_state)
            rbvi_pkg::S_IDLE: begin
                // Take a tick transaction
                if (w_in_acc) begin
                    n_fx     = $signed(i_s_axis_tdata[W-1:0]);
                    n_fy     = $signed(i_s_axis_tdata[2*W-1:W]);
                    n_dt     = i_s_axis_tdata[DT_LO +: DTW];
                    n_px     = $signed(i_s_axis_tdata[PX_LO +: W]);
                    n_py     = $signed(i_s_axis_tdata[PY_LO +: W]);
                    n_ground = i_s_axis_tuser;
                    n_state  = r_enabled ? rbvi_pkg::S_DIVX : rbvi_pkg::S_OUT;
                end
            end
            rbvi_pkg::S_DIVX: begin
                if (w_alu_done) begin
                    n_t     = (r_fx == '0) ? '0 : f_make(r_fx[W-1], w_res);
                    n_state = rbvi_pkg::S_MULX;
                end
            end
            rbvi_pkg::S_MULX: begin
                if (w_alu_done) begin
                    n_vx    = f_sadd(r_vx, f_make(r_t[W-1], w_prod_f));
                    n_state = rbvi_pkg::S_DIVY;
                end
            end
            rbvi_pkg::S_DIVY: begin
                if (w_alu_done) begin
                    n_t     = (r_fy == '0) ? '0 : f_make(r_fy[W-1], w_res);
                    n_state = rbvi_pkg::S_MULY;
                end
            end
            rbvi_pkg::S_MULY: begin
                if (w_alu_done) begin
                    n_vy = f_sadd(r_vy, f_make(r_t[W-1], w_prod_f));
                    if (w_fric) begin
                        n_state = rbvi_pkg::S_FR1;
                    end else if (w_air && (r_vx != '0)) begin
                        n_s     = w_drag;
                        n_phase = rbvi_pkg::PH_AIR;
                        n_state = rbvi_pkg::S_SQX;
                    end else if (w_gr) begin
                        n_state = rbvi_pkg::S_GRAV;
                    end else begin
                        l_lim = 1'b1;
                    end
                end
            end
            rbvi_pkg::S_FR1: begin
                if (w_alu_done) begin
                    n_t     = w_sres;
                    n_state = rbvi_pkg::S_FR2;
                end
            end
            rbvi_pkg::S_FR2: begin
                if (w_alu_done) begin
                    n_s     = w_sres;
                    n_phase = rbvi_pkg::PH_FRIC;
                    n_state = rbvi_pkg::S_SQX;
                end
            end
            rbvi_pkg::S_SQX: begin
                if (w_alu_done) begin
                    n_wide  = w_res;
                    n_state = rbvi_pkg::S_SQY;
                end
            end
            rbvi_pkg::S_SQY: begin
                if (w_alu_done) begin
                    n_wide  = r_wide + w_res;
                    n_state = rbvi_pkg::S_SQRT;
                end
            end
            rbvi_pkg::S_SQRT: begin
                if (w_alu_done) begin
                    n_len = w_res[W-1:0];
                    case (r_phase)
                        rbvi_pkg::PH_FRIC: begin
                            // Snap to rest when the friction step covers the speed
                            if (w_res[W-1:0] <= r_s) begin
                                n_vx  = '0;
                                n_vy  = '0;
                                l_lim = 1'b1;
                            end else begin
                                n_state = rbvi_pkg::S_SCX;
                            end
                        end
                        rbvi_pkg::PH_AIR: begin
                            if (w_res[W-1:0] <= r_s) begin
                                n_vx = '0;
                            end else if (!r_vx[W-1]) begin
                                n_vx = f_ssub(r_vx, $signed(r_s));
                            end else begin
                                n_vx = f_sadd(r_vx, $signed(r_s));
                            end
                            n_state = rbvi_pkg::S_GRAV;
                        end
                        default: begin
                            n_state = (w_res[W-1:0] > r_s) ? rbvi_pkg::S_SCX
                                                           : rbvi_pkg::S_POSX;
                        end
                    endcase
                end
            end
            rbvi_pkg::S_SCX: begin
                if (w_alu_done) begin
                    n_wide  = w_res;
                    n_state = rbvi_pkg::S_SDX;
                end
            end
            rbvi_pkg::S_SDX: begin
                if (w_alu_done) begin
                    if (r_phase == rbvi_pkg::PH_FRIC) begin
                        n_vx = f_ssub(r_vx, f_make(r_vx[W-1], w_res));
                    end else begin
                        n_vx = f_make(r_vx[W-1], w_res);
                    end
                    n_state = rbvi_pkg::S_SCY;
                end
            end
            rbvi_pkg::S_SCY: begin
                if (w_alu_done) begin
                    n_wide  = w_res;
                    n_state = rbvi_pkg::S_SDY;
                end
            end
            rbvi_pkg::S_SDY: begin
                if (w_alu_done) begin
                    if (r_phase == rbvi_pkg::PH_FRIC) begin
                        n_vy  = f_ssub(r_vy, f_make(r_vy[W-1], w_res));
                        l_lim = 1'b1;
                    end else begin
                        n_vy    = f_make(r_vy[W-1], w_res);
                        n_state = rbvi_pkg::S_POSX;
                    end
                end
            end
            rbvi_pkg::S_GRAV: begin
                if (w_alu_done) begin
                    n_vy  = f_ssub(r_vy, w_sres);
                    l_lim = 1'b1;
                end
            end
            rbvi_pkg::S_CLAMP: begin
                // Per-axis speed limits under gravity
                if (w_mvx > w_vl) begin
                    n_vx = r_vx[W-1] ? $signed(~w_vl + W'(1)) : $signed(w_vl);
                end
                if (w_mvy > w_gl) begin
                    n_vy = r_vy[W-1] ? $signed(~w_gl + W'(1)) : $signed(w_gl);
                end
                n_state = rbvi_pkg::S_POSX;
            end
            rbvi_pkg::S_POSX: begin
                if (w_alu_done) begin
                    n_px    = f_sadd(r_px, f_make(r_vx[W-1], w_prod_f));
                    n_state = rbvi_pkg::S_POSY;
                end
            end
            rbvi_pkg::S_POSY: begin
                if (w_alu_done) begin
                    n_py    = f_sadd(r_py, f_make(r_vy[W-1], w_prod_f));
                    n_state = rbvi_pkg::S_OUT;
                end
            end
            rbvi_pkg::S_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_data  = {r_vy, r_vx, r_py, r_px};
                    n_out_valid = 1'b1;
                    n_state     = rbvi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rbvi_pkg::S_IDLE;
            end
        endcase

        // Enter the speed limit stage
        if (l_lim) begin
            if (r_grav) begin
                n_state = rbvi_pkg::S_CLAMP;
            end else begin
                n_s     = w_vl;
                n_phase = rbvi_pkg::PH_LIM;
                n_state = rbvi_pkg::S_SQX;
            end
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbvi_pkg::S_IDLE;
            r_phase     <= rbvi_pkg::PH_FRIC;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_vx        <= '0;
            r_vy        <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_vx        <= n_vx;
            r_vy        <= n_vy;
        end
    end

    // Working and output payload
    always_ff @(posedge i_clk) begin
        r_fx       <= n_fx;
        r_fy       <= n_fy;
        r_px       <= n_px;
        r_py       <= n_py;
        r_dt       <= n_dt;
        r_ground   <= n_ground;
        r_t        <= n_t;
        r_s        <= n_s;
        r_len      <= n_len;
        r_wide     <= n_wide;
        r_out_data <= n_out_data;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
            r_grav    <= 1'b0;
            r_air     <= 1'b1;
            r_mass    <= RST_MASS;
            r_fric    <= RST_FRIC;
            r_vlim    <= RST_VLIM;
            r_glim    <= RST_GLIM;
            r_gacc    <= RST_GACC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rbvi_pkg::t_cfg_reg'(i_cfg_index))
                rbvi_pkg::REG_ENABLED:        r_enabled <= i_cfg_data[0];
                rbvi_pkg::REG_GRAVITY_USE:    r_grav    <= i_cfg_data[0];
                rbvi_pkg::REG_AIR_FRICTION:   r_air     <= i_cfg_data[0];
                rbvi_pkg::REG_MASS:           r_mass    <= i_cfg_data;
                rbvi_pkg::REG_FRICTION_RATE:  r_fric    <= i_cfg_data;
                rbvi_pkg::REG_VELOCITY_LIMIT: r_vlim    <= i_cfg_data;
                rbvi_pkg::REG_GRAVITY_LIMIT:  r_glim    <= i_cfg_data;
                rbvi_pkg::REG_GRAVITY_ACCEL:  r_gacc    <= i_cfg_data;
                default: begin
                    r_enabled <= r_enabled;
                end
            endcase
        end
    end

    // ---- checks ----
    `RBVI_ASSERT_IMP(a_done_issued, i_clk, i_rst_n, w_alu_done, r_issued, "unit result without an issued operation")
    `RBVI_ASSERT_NXT(a_pass_through, i_clk, i_rst_n, w_in_acc && !r_enabled, r_state == rbvi_pkg::S_OUT, "disabled tick did not pass straight through")
    `RBVI_ASSERT_NXT(a_vel_hold, i_clk, i_rst_n, r_state == rbvi_pkg::S_IDLE, $stable(r_vx) && $stable(r_vy), "velocity changed while idle")

endmodule

// ===== tb/rigid_body_velocity_integrator_2d_test.sv =====
// ----------------------------------------------------------------------------
// Testbench of the 2D rigid body velocity integrator
// Drives tick transactions in random bursts through the streaming input,
// stalls the result stream on a random pattern and predicts every result with
// an exact fixed-point model of the Euler step, friction, gravity and limits.
// Configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module rigid_body_velocity_integrator_2d_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = rbvi_pkg::VALUE_BITS_DEF;
    localparam int FB = rbvi_pkg::FRAC_BITS_DEF;
    localparam int CFGB = rbvi_pkg::CFG_BITS;
    localparam int IN_W  = ((4*VB+FB+1+7)/8)*8;
    localparam int OUT_W = ((4*VB+7)/8)*8;
    localparam longint VMAX = (longint'(1) << (VB-1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam longint CFG_MAX = (longint'(1) << CFGB) - 1;
    localparam longint ONE = longint'(1) << FB;
    localparam int LIMIT_CYCLES = 4000000;

    typedef logic [127:0] t_u128;

    typedef struct {
        logic signed [VB-1:0] fx;
        logic signed [VB-1:0] fy;
        logic [FB:0]          dt;
        logic                 ground;
        logic signed [VB-1:0] px;
        logic signed [VB-1:0] py;
    } t_tick;

    typedef struct {
        logic signed [VB-1:0] px;
        logic signed [VB-1:0] py;
        logic signed [VB-1:0] vx;
        logic signed [VB-1:0] vy;
    } t_body;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [rbvi_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFGB-1:0]                   i_cfg_data;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [IN_W-1:0]                   i_s_axis_tdata;
    logic                              i_s_axis_tuser;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    logic [OUT_W-1:0]                  o_m_axis_tdata;

    rigid_body_velocity_integrator_2d i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Shadow of the block: registers and stored velocity
    logic   cfg_en, cfg_grav, cfg_air;
    longint cfg_mass, cfg_fric, cfg_vlim, cfg_glim, cfg_gacc;
    longint body_vx, body_vy;

    t_tick tick_queue[$];
    t_body body_expected[$];
    int    mismatches;
    int    cycle_count;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Exact fixed-point arithmetic
    // ------------------------------------------------------------------
    function automatic t_u128 mag(longint v);
        return v < 0 ? t_u128'(-v) : t_u128'(v);
    endfunction

    function automatic longint sat_mag(bit neg, t_u128 m);
        t_u128 lim;
        lim = neg ? t_u128'(VMAX) + 1 : t_u128'(VMAX);
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        return s > VMAX ? VMAX : (s < VMIN ? VMIN : s);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return sat_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> FB);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        if (a == 0) return 0;
        if (b == 0) return sat_mag(a < 0, t_u128'(1) << 64);
        return sat_mag((a < 0) != (b < 0), (mag(a) << FB) / mag(b));
    endfunction

    // c*s/len toward zero
    function automatic longint along(longint c, longint s, t_u128 len);
        return sat_mag(c < 0, (mag(c) * mag(s)) / len);
    endfunction

    function automatic t_u128 length(longint x, longint y);
        t_u128 n, r, c;
        n = mag(x) * mag(x) + mag(y) * mag(y);
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (t_u128'(1) << i);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    // One Euler tick of the body; advances the stored velocity when enabled
    function automatic t_body integrate_tick(t_tick t);
        t_body  r;
        longint vx, vy, px, py, dt, f, d, dx, dy, nx, ny;
        t_u128  len;
        vx = body_vx;
        vy = body_vy;
        px = t.px;
        py = t.py;
        dt = longint'(t.dt);
        if (cfg_en) begin
            vx = sat_add(vx, fx_mul(fx_div(t.fx, cfg_mass), dt));
            vy = sat_add(vy, fx_mul(fx_div(t.fy, cfg_mass), dt));
            // Vector friction on ground or without gravity
            if (!cfg_grav || t.ground) begin
                f = fx_mul(fx_mul(cfg_fric, cfg_mass), dt);
                len = length(vx, vy);
                if (len <= t_u128'(f)) begin
                    vx = 0;
                    vy = 0;
                end else begin
                    dx = along(vx, f, len);
                    dy = along(vy, f, len);
                    vx = sat_add(vx, -dx);
                    vy = sat_add(vy, -dy);
                end
            end
            // Horizontal drag in the air, judged on the full speed
            if (cfg_grav && !t.ground && cfg_air && vx != 0) begin
                d = rbvi_pkg::DRAG_K * dt;
                if (d > VMAX) d = VMAX;
                len = length(vx, vy);
                if (len <= t_u128'(d)) vx = 0;
                else vx = vx > 0 ? sat_add(vx, -d) : sat_add(vx, d);
            end
            if (cfg_grav && !t.ground)
                vy = sat_add(vy, -fx_mul(cfg_gacc, dt));
            // Speed limits
            if (cfg_grav) begin
                if (mag(vx) > t_u128'(cfg_vlim)) vx = vx < 0 ? -cfg_vlim : cfg_vlim;
                if (mag(vy) > t_u128'(cfg_glim)) vy = vy < 0 ? -cfg_glim : cfg_glim;
            end else begin
                len = length(vx, vy);
                if (len > t_u128'(cfg_vlim)) begin
                    nx = along(vx, cfg_vlim, len);
                    ny = along(vy, cfg_vlim, len);
                    vx = nx;
                    vy = ny;
                end
            end
            px = sat_add(px, fx_mul(vx, dt));
            py = sat_add(py, fx_mul(vy, dt));
            body_vx = vx;
            body_vy = vy;
        end
        r.px = px[VB-1:0];
        r.py = py[VB-1:0];
        r.vx = vx[VB-1:0];
        r.vy = vy[VB-1:0];
        return r;
    endfunction

    // Track register writes as the block takes them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_en   <= 1'b1;
            cfg_grav <= 1'b0;
            cfg_air  <= 1'b1;
            cfg_mass <= longint'(rbvi_pkg::MASS_K) << FB;
            cfg_fric <= longint'(rbvi_pkg::FRIC_K) << FB;
            cfg_vlim <= longint'(rbvi_pkg::VLIM_K) << FB;
            cfg_glim <= longint'(rbvi_pkg::GLIM_K) << FB;
            cfg_gacc <= longint'(rbvi_pkg::GACC_K) << FB;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rbvi_pkg::t_cfg_reg'(i_cfg_index))
                rbvi_pkg::REG_ENABLED:        cfg_en   <= i_cfg_data[0];
                rbvi_pkg::REG_GRAVITY_USE:    cfg_grav <= i_cfg_data[0];
                rbvi_pkg::REG_AIR_FRICTION:   cfg_air  <= i_cfg_data[0];
                rbvi_pkg::REG_MASS:           cfg_mass <= longint'(i_cfg_data);
                rbvi_pkg::REG_FRICTION_RATE:  cfg_fric <= longint'(i_cfg_data);
                rbvi_pkg::REG_VELOCITY_LIMIT: cfg_vlim <= longint'(i_cfg_data);
                rbvi_pkg::REG_GRAVITY_LIMIT:  cfg_glim <= longint'(i_cfg_data);
                rbvi_pkg::REG_GRAVITY_ACCEL:  cfg_gacc <= longint'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tick driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_tick t;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tuser  <= 1'b0;
            burst_left      <= 1;
            gap_left        <= 0;
            body_vx         <= 0;
            body_vy         <= 0;
        end else begin
            // Predict each accepted transaction in order
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                t.fx     = i_s_axis_tdata[VB-1:0];
                t.fy     = i_s_axis_tdata[2*VB-1:VB];
                t.dt     = i_s_axis_tdata[2*VB+FB:2*VB];
                t.px     = i_s_axis_tdata[3*VB+FB:2*VB+FB+1];
                t.py     = i_s_axis_tdata[4*VB+FB:3*VB+FB+1];
                t.ground = i_s_axis_tuser;
                body_expected.push_back(integrate_tick(t));
            end
            // Hold while the current transaction waits
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left        <= gap_left - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    t = tick_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {{(IN_W-4*VB-FB-1){1'b0}},
                                        t.py, t.px, t.dt, t.fy, t.fx};
                    i_s_axis_tuser  <= t.ground;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                                                  : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result stall pattern, renewed whenever its phase counter wraps
    logic [31:0] stall_pattern;
    int          stall_phase;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_pattern   <= '1;
            stall_phase     <= 0;
        end else begin
            if (stall_phase == 31) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= '1;
                    1:       stall_pattern <= $urandom & $urandom;
                    default: stall_pattern <= $urandom;
                endcase
            end
            stall_phase     <= (stall_phase + 1) % 32;
            i_m_axis_tready <= stall_pattern[stall_phase];
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_body got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.px = o_m_axis_tdata[VB-1:0];
            got.py = o_m_axis_tdata[2*VB-1:VB];
            got.vx = o_m_axis_tdata[3*VB-1:2*VB];
            got.vy = o_m_axis_tdata[4*VB-1:3*VB];
            if (body_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result px=%0d py=%0d vx=%0d vy=%0d",
                             got.px, got.py, got.vx, got.vy);
            end else begin
                want = body_expected.pop_front();
                if (got.px !== want.px || got.py !== want.py ||
                    got.vx !== want.vx || got.vy !== want.vy) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: px %0d/%0d py %0d/%0d vx %0d/%0d vy %0d/%0d",
                                 want.px, got.px, want.py, got.py,
                                 want.vx, got.vx, want.vy, got.vy);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(rbvi_pkg::t_cfg_reg idx, longint value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFGB-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_tick(longint fx, longint fy, longint dt, bit g,
                            longint px, longint py);
        t_tick t;
        t.fx = fx[VB-1:0];
        t.fy = fy[VB-1:0];
        t.dt = dt[FB:0];
        t.ground = g;
        t.px = px[VB-1:0];
        t.py = py[VB-1:0];
        tick_queue.push_back(t);
    endtask

    // Wait for every result, then let the block settle
    task automatic drain();
        while (tick_queue.size() > 0 || i_s_axis_tvalid || body_expected.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic longint any40();
        return longint'({$urandom, $urandom}) <<< 24 >>> 24;
    endfunction

    function automatic longint modest(int bits);
        longint v;
        v = longint'($urandom) & ((longint'(1) << bits) - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic longint pick_cfg(int bits);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return CFG_MAX;
            default: return longint'($urandom_range(1, 1 << bits));
        endcase
    endfunction

    function automatic longint pick_dt();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return ONE;
            2:       return $urandom_range(0, ONE);
            default: return $urandom_range(1, 4000);
        endcase
    endfunction

    initial begin
        cycle_count     = 0;
        mismatches      = 0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: vector friction and vector limit
        add_tick(0, 0, 1092, 0, 0, 0);
        add_tick(1000 * ONE, -2000 * ONE, 1092, 0, 5 * ONE, -5 * ONE);
        add_tick(VMAX, VMIN, ONE, 1, VMAX, VMIN);
        add_tick(VMIN, VMAX, ONE, 0, VMIN, VMAX);
        add_tick(0, 0, 0, 0, 12345, -12345);
        add_tick(3 * ONE, 4 * ONE, 30, 1, 0, 0);
        drain();

        // Gravity with air drag, including drag crossing zero
        write_reg(rbvi_pkg::REG_GRAVITY_USE, 1);
        add_tick(500 * ONE, 0, 1092, 1, 0, 0);
        add_tick(20000 * ONE, 0, 1092, 0, 0, 100 * ONE);
        add_tick(0, 0, 1092, 0, 7 * ONE, 7 * ONE);
        add_tick(-40000 * ONE, 90000 * ONE, ONE, 0, VMAX, VMAX);
        add_tick(0, 0, 0, 0, 0, 0);
        drain();

        // No air drag, zero mass, zero limits
        write_reg(rbvi_pkg::REG_AIR_FRICTION, 0);
        write_reg(rbvi_pkg::REG_MASS, 0);
        write_reg(rbvi_pkg::REG_VELOCITY_LIMIT, 0);
        write_reg(rbvi_pkg::REG_GRAVITY_LIMIT, 0);
        add_tick(ONE, -ONE, 1092, 0, ONE, ONE);
        add_tick(0, 0, 1092, 1, 0, 0);
        drain();

        // Extreme registers, no gravity
        write_reg(rbvi_pkg::REG_GRAVITY_USE, 0);
        write_reg(rbvi_pkg::REG_MASS, CFG_MAX);
        write_reg(rbvi_pkg::REG_FRICTION_RATE, 0);
        write_reg(rbvi_pkg::REG_VELOCITY_LIMIT, CFG_MAX);
        write_reg(rbvi_pkg::REG_GRAVITY_ACCEL, CFG_MAX);
        add_tick(VMAX, VMAX, ONE, 0, 0, 0);
        add_tick(VMIN, 1, ONE, 1, VMIN, VMIN);
        drain();

        // Pass-through
        write_reg(rbvi_pkg::REG_ENABLED, 0);
        add_tick(VMAX, VMIN, ONE, 1, -3 * ONE, 4 * ONE);
        add_tick(any40(), any40(), ONE, 0, any40(), any40());
        drain();

        // Random phases, each with fresh settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(rbvi_pkg::REG_ENABLED, $urandom_range(0, 7) != 0);
            write_reg(rbvi_pkg::REG_GRAVITY_USE, $urandom_range(0, 1));
            write_reg(rbvi_pkg::REG_AIR_FRICTION, $urandom_range(0, 1));
            write_reg(rbvi_pkg::REG_MASS,
                      ($urandom_range(0, 3) == 0) ? pick_cfg(20)
                                                  : $urandom_range(ONE / 4, 8 * ONE));
            write_reg(rbvi_pkg::REG_FRICTION_RATE, pick_cfg(28));
            write_reg(rbvi_pkg::REG_VELOCITY_LIMIT, pick_cfg(28));
            write_reg(rbvi_pkg::REG_GRAVITY_LIMIT, pick_cfg(28));
            write_reg(rbvi_pkg::REG_GRAVITY_ACCEL, pick_cfg(30));
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 9) == 0)
                    add_tick(any40(), any40(), $urandom_range(0, 2 * ONE - 1),
                             $urandom_range(0, 1), any40(), any40());
                else
                    add_tick(modest(30), modest(30), pick_dt(), $urandom_range(0, 1),
                             any40(), modest(34));
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && body_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
